/* src/pst_pkg.sv */
// shared types, constants and helpers for the pit speaker tone synth
`timescale 1ns / 1ps
package pst_pkg;

    localparam int PHASE_W    = 52;
    localparam int FRAC_W     = 32;
    localparam int INT_W      = PHASE_W - FRAC_W;
    localparam int CNT_W      = 17;
    localparam int STEP_W     = 40;
    localparam int LVL_W      = 8;
    localparam int BURST_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW     = 2'd3;

    localparam logic [LVL_W-1:0] RST_SILENCE = 8'd128;
    localparam logic [LVL_W-1:0] RST_HIGH    = 8'd255;
    localparam logic [LVL_W-1:0] RST_LOW     = 8'd0;

    localparam logic [2:0] MODE_TERM        = 3'd0;
    localparam logic [2:0] MODE_ONESHOT     = 3'd1;
    localparam logic [2:0] MODE_RATE        = 3'd2;
    localparam logic [2:0] MODE_SQUARE      = 3'd3;
    localparam logic [2:0] MODE_SW_STROBE   = 3'd4;
    localparam logic [2:0] MODE_HW_STROBE   = 3'd5;
    localparam logic [2:0] MODE_RATE_ALT    = 3'd6;
    localparam logic [2:0] MODE_SQUARE_ALT  = 3'd7;

    localparam logic [CNT_W-1:0] FULL_COUNT = 17'h10000;

    typedef struct packed {
        logic [15:0]        reload_value;
        logic [2:0]         timer_mode;
        logic               gate_level;
        logic               speaker_on;
        logic [15:0]        generation;
        logic [BURST_W-1:0] burst_len;
    } t_in_item;

    typedef struct packed {
        logic [LVL_W-1:0] sample_value;
        logic             last_sample;
    } t_out_item;

    typedef struct packed {
        logic load_item;
        logic div_start;
        logic take_rem;
        logic load_out;
        logic add_step;
        logic clamp;
    } t_dp_cmd;

    typedef struct packed {
        logic remain_zero;
        logic remain_one;
        logic gate;
        logic mod_mode;
        logic div_done;
        logic out_free;
    } t_dp_stat;

    function automatic logic [2:0] canon_mode(input logic [2:0] m);
        logic [2:0] r;
        case (m)
            MODE_RATE_ALT:   r = MODE_RATE;
            MODE_SQUARE_ALT: r = MODE_SQUARE;
            default:         r = m;
        endcase
        return r;
    endfunction

endpackage

/* src/pit_speaker_tone_synth_core.sv */
// top level of the pit speaker tone synth
// sequence: request loaded and checked, then first sample registered; when the
//   gate is high in modes 2 and 3 the phase gets a remainder pass first
// throughput: one sample per cycle with gate low, unless the output stalls;
//   clamped modes add and clamp after each sample, modes 2 and 3 add and reduce
// reset: synchronous active low, clears phase and held control word and
//   loads register defaults; no clearing pass
`timescale 1ns / 1ps
module pit_speaker_tone_synth_core #(
    parameter int MAX_BURST = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pst_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pst_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pst_pkg::t_out_item             o_out_data
);
    import pst_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pst_dp #(
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* src/pst_div.sv */
// restoring remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
module pst_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pst_pkg::INT_W-1:0] i_dividend,
    input  logic [pst_pkg::CNT_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [pst_pkg::CNT_W-1:0] o_rem
);
    import pst_pkg::*;

    localparam int ITER_W = $clog2(INT_W);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(INT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_iter;
    logic [INT_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic [CNT_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[INT_W-1]};
        diff  = trial - {1'b0, i_divisor};
        n_rem = (trial >= {1'b0, i_divisor}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == LAST_ITER) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[INT_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* src/pst_dp.sv */
// datapath: config registers, held control word, phase, output register
`timescale 1ns / 1ps
module pst_dp #(
    parameter int MAX_BURST = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pst_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  pst_pkg::t_in_item              i_in_data,
    input  pst_pkg::t_dp_cmd               i_cmd,
    output pst_pkg::t_dp_stat              o_stat,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pst_pkg::t_out_item             o_out_data
);
    import pst_pkg::*;

    localparam logic [BURST_W-1:0] BURST_MAX = BURST_W'(MAX_BURST);

    logic [STEP_W-1:0]  r_step;
    logic [LVL_W-1:0]   r_lvl_silence;
    logic [LVL_W-1:0]   r_lvl_high;
    logic [LVL_W-1:0]   r_lvl_low;
    logic [PHASE_W-1:0] r_phase;
    logic [15:0]        r_held_reload;
    logic [2:0]         r_held_mode;
    logic               r_held_gate;
    logic [15:0]        r_held_gen;
    logic               r_spk;
    logic [BURST_W-1:0] r_remain;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [CNT_W-1:0]   cnt;
    logic [CNT_W:0]     cnt_inc;
    logic [CNT_W-1:0]   half;
    logic [2:0]         cm;
    logic [2:0]         in_cm;
    logic [INT_W-1:0]   pint;
    logic               level;
    logic               mod_mode;
    logic               retrig;
    logic [BURST_W-1:0] sat_cnt;
    logic [PHASE_W-1:0] term;
    logic [PHASE_W-1:0] sum;
    logic               out_free;
    logic               div_done;
    logic [CNT_W-1:0]   div_rem;

    always_comb begin
        cnt      = (r_held_reload == 16'd0) ? FULL_COUNT : {1'b0, r_held_reload};
        cnt_inc  = {1'b0, cnt} + 1'b1;
        half     = cnt_inc[CNT_W:1];
        cm       = canon_mode(r_held_mode);
        in_cm    = canon_mode(i_in_data.timer_mode);
        pint     = r_phase[PHASE_W-1:FRAC_W];
        mod_mode = (cm == MODE_RATE) || (cm == MODE_SQUARE);
        term     = {3'b000, cnt_inc[CNT_W-1:0], {FRAC_W{1'b0}}};
        sum      = r_phase + {{(PHASE_W-STEP_W){1'b0}}, r_step};
        out_free = !r_out_valid || i_out_ready;
        sat_cnt  = (i_in_data.burst_len > BURST_MAX) ? BURST_MAX : i_in_data.burst_len;
        retrig   = (i_in_data.generation != r_held_gen) &&
                   ((i_in_data.reload_value != r_held_reload) ||
                    (in_cm != canon_mode(r_held_mode)) ||
                    (i_in_data.gate_level && !r_held_gate) ||
                    (in_cm == MODE_ONESHOT) || (in_cm == MODE_HW_STROBE));
        if (!r_held_gate) begin
            level = !((cm == MODE_TERM) || (cm == MODE_ONESHOT));
        end else begin
            case (cm)
                MODE_TERM, MODE_ONESHOT: level = pint >= {3'b000, cnt};
                MODE_RATE:               level = pint < {3'b000, cnt - 1'b1};
                MODE_SQUARE:             level = pint < {3'b000, half};
                default:                 level = pint != {3'b000, cnt};
            endcase
        end
    end

    pst_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (pint),
        .i_divisor  (cnt),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= '0;
            r_lvl_silence <= RST_SILENCE;
            r_lvl_high    <= RST_HIGH;
            r_lvl_low     <= RST_LOW;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP:    r_step        <= i_cfg_wdata[STEP_W-1:0];
                CFG_SILENCE: r_lvl_silence <= i_cfg_wdata[LVL_W-1:0];
                CFG_HIGH:    r_lvl_high    <= i_cfg_wdata[LVL_W-1:0];
                CFG_LOW:     r_lvl_low     <= i_cfg_wdata[LVL_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_held_reload <= '0;
            r_held_mode   <= '0;
            r_held_gate   <= 1'b0;
            r_held_gen    <= '0;
            r_spk         <= 1'b0;
            r_remain      <= '0;
        end else begin
            if (i_cmd.load_item) begin
                if (retrig) begin
                    r_phase <= '0;
                end
                r_held_reload <= i_in_data.reload_value;
                r_held_mode   <= i_in_data.timer_mode;
                r_held_gate   <= i_in_data.gate_level;
                r_held_gen    <= i_in_data.generation;
                r_spk         <= i_in_data.speaker_on;
                r_remain      <= sat_cnt;
            end else if (i_cmd.add_step) begin
                r_phase <= sum;
            end else if (i_cmd.clamp) begin
                if (r_phase > term) begin
                    r_phase <= term;
                end
            end else if (i_cmd.take_rem) begin
                r_phase <= {{(INT_W-CNT_W){1'b0}}, div_rem, r_phase[FRAC_W-1:0]};
            end
            if (i_cmd.load_out) begin
                r_remain <= r_remain - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.sample_value <= !r_spk ? r_lvl_silence :
                                       (level ? r_lvl_high : r_lvl_low);
            r_out_data.last_sample  <= (r_remain == BURST_W'(1));
        end
    end

    always_comb begin
        o_stat.remain_zero = (r_remain == '0);
        o_stat.remain_one  = (r_remain == BURST_W'(1));
        o_stat.gate        = r_held_gate;
        o_stat.mod_mode    = mod_mode;
        o_stat.div_done    = div_done;
        o_stat.out_free    = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* src/pst_ctrl.sv */
// controller: sequences retrigger, sample emit, phase advance and reduction
`timescale 1ns / 1ps
module pst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pst_pkg::t_dp_stat i_stat,
    output pst_pkg::t_dp_cmd  o_cmd
);
    import pst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PDIV,
        S_EMIT,
        S_ADD,
        S_FIX,
        S_DIV
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.remain_zero) begin
                    n_state = S_IDLE;
                end else if (i_stat.gate && i_stat.mod_mode) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_PDIV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_PDIV: begin
                if (i_stat.div_done) begin
                    o_cmd.take_rem = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    if (i_stat.gate) begin
                        n_state = S_ADD;
                    end else if (i_stat.remain_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ADD: begin
                o_cmd.add_step = 1'b1;
                n_state        = S_FIX;
            end
            S_FIX: begin
                if (i_stat.mod_mode) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.clamp = 1'b1;
                    n_state     = i_stat.remain_zero ? S_IDLE : S_EMIT;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.take_rem = 1'b1;
                    n_state        = i_stat.remain_zero ? S_IDLE : S_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

/* src/pst_checker.sv */
// port-level checks for the pit speaker tone synth, bound to the top level
`timescale 1ns / 1ps
module pst_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pst_pkg::t_out_item o_out_data
);
    import pst_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after a request");

    a_mid_burst_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last_sample) |-> !o_in_ready)
        else $error("idle with samples of the burst left");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled sample changed");

endmodule

bind pit_speaker_tone_synth_core pst_checker u_pst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
